/* rtl/plar_pkg.sv */
// Package: shared types, widths and codes of the polyline arc-length resampler.
package plar_pkg;

   localparam int COORD_WIDTH   = 24;
   localparam int SPACING_WIDTH = 23;
   localparam int REM_WIDTH     = 24;
   localparam int DELTA_WIDTH   = COORD_WIDTH + 1;
   localparam int SQ_WIDTH      = 2 * DELTA_WIDTH;
   localparam int PROD_WIDTH    = DELTA_WIDTH + REM_WIDTH;
   localparam int ITER_WIDTH    = $clog2(DELTA_WIDTH);

   localparam logic [SPACING_WIDTH-1:0] SPACING_RESET = SPACING_WIDTH'(256);

   localparam logic [1:0] KIND_CONT  = 2'd0;
   localparam logic [1:0] KIND_FIRST = 2'd1;
   localparam logic [1:0] KIND_LAST  = 2'd2;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic                          first_vertex;
      logic                          last_vertex;
   } req_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] out_x;
      logic signed [COORD_WIDTH-1:0] out_y;
      logic                          run_end;
      logic                          overflow;
   } rsp_type;

   typedef struct packed {
      logic signed [COORD_WIDTH-1:0] pos_x;
      logic signed [COORD_WIDTH-1:0] pos_y;
      logic [1:0]                    kind;
   } cmd_type;

endpackage

/* rtl/plar_front.sv */
// Front end: accepts vertices, classifies them and holds them in a two-entry queue.
module plar_front (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   output logic               full,
   input  plar_pkg::req_type  req_data,
   output logic               cmd_valid,
   input  logic               cmd_pop,
   output plar_pkg::cmd_type  cmd
);

   plar_pkg::cmd_type slot_ff [2];
   plar_pkg::cmd_type slot_in;
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign full      = (count_ff == 2'd2);
   assign cmd_valid = (count_ff != 2'd0);
   assign cmd       = slot_ff[rd_ptr_ff];
   assign do_push   = push && !full;
   assign do_pop    = cmd_pop && cmd_valid;

   always_comb begin
      slot_in.pos_x = req_data.pos_x;
      slot_in.pos_y = req_data.pos_y;
      // A first vertex takes precedence when both marks are set.
      if (req_data.first_vertex) begin
         slot_in.kind = plar_pkg::KIND_FIRST;
      end else if (req_data.last_vertex) begin
         slot_in.kind = plar_pkg::KIND_LAST;
      end else begin
         slot_in.kind = plar_pkg::KIND_CONT;
      end
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= slot_in;
      end
   end

endmodule

/* rtl/plar_rsp_fifo.sv */
// Result queue: two entries between the engine and the result ports.
module plar_rsp_fifo (
   input  logic               clock,
   input  logic               reset,
   input  logic               in_push,
   input  plar_pkg::rsp_type  in_item,
   output logic               in_full,
   output logic               empty,
   input  logic               pop,
   output plar_pkg::rsp_type  rsp_data
);

   plar_pkg::rsp_type slot_ff [2];
   logic       wr_ptr_ff, wr_ptr_in;
   logic       rd_ptr_ff, rd_ptr_in;
   logic [1:0] count_ff, count_in;
   logic       do_push, do_pop;

   assign in_full  = (count_ff == 2'd2);
   assign empty    = (count_ff == 2'd0);
   assign rsp_data = slot_ff[rd_ptr_ff];
   assign do_push  = in_push && !in_full;
   assign do_pop   = pop && !empty;

   always_comb begin
      wr_ptr_in = do_push ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_pop ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= in_item;
      end
   end

endmodule

/* rtl/plar_engine.sv */
// Back end: measures segments with a bit-serial square root and interpolates with a serial divider.
module plar_engine #(
   parameter int MAX_PER_SEGMENT = 63
) (
   input  logic                                 clock,
   input  logic                                 reset,
   input  logic                                 cmd_valid,
   input  plar_pkg::cmd_type                    cmd,
   output logic                                 cmd_pop,
   input  logic [plar_pkg::SPACING_WIDTH-1:0]   spacing,
   input  logic                                 out_full,
   output logic                                 out_push,
   output plar_pkg::rsp_type                    out_item
);

   localparam int CW = plar_pkg::COORD_WIDTH;
   localparam int DW = plar_pkg::DELTA_WIDTH;
   localparam int RW = plar_pkg::REM_WIDTH;
   localparam int SW = plar_pkg::SQ_WIDTH;
   localparam int PW = plar_pkg::PROD_WIDTH;
   localparam int IW = plar_pkg::ITER_WIDTH;
   localparam int MW = $clog2(MAX_PER_SEGMENT + 1);

   localparam logic [3:0] ST_IDLE   = 4'd0;
   localparam logic [3:0] ST_DELTA  = 4'd1;
   localparam logic [3:0] ST_SQUARE = 4'd2;
   localparam logic [3:0] ST_SUM    = 4'd3;
   localparam logic [3:0] ST_SQRT   = 4'd4;
   localparam logic [3:0] ST_DECIDE = 4'd5;
   localparam logic [3:0] ST_MULT   = 4'd6;
   localparam logic [3:0] ST_DIV    = 4'd7;
   localparam logic [3:0] ST_STEP   = 4'd8;
   localparam logic [3:0] ST_FINISH = 4'd9;

   logic [3:0]          state_ff, state_in;
   logic signed [CW-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [CW-1:0] last_x_ff, last_x_in, last_y_ff, last_y_in;
   logic signed [CW-1:0] pend_x_ff, pend_x_in, pend_y_ff, pend_y_in;
   logic                last_flag_ff, last_flag_in;
   logic [RW-1:0]       remaining_ff, remaining_in;
   logic                neg_x_ff, neg_x_in, neg_y_ff, neg_y_in;
   logic [DW-1:0]       ax_ff, ax_in, ay_ff, ay_in;
   logic [SW-1:0]       sqx_ff, sqx_in, sqy_ff, sqy_in;
   logic [SW-1:0]       rad_ff, rad_in;
   logic [DW+2:0]       sq_rem_ff, sq_rem_in;
   logic [DW-1:0]       root_ff, root_in;
   logic [IW-1:0]       iter_ff, iter_in;
   logic [MW-1:0]       made_ff, made_in;
   logic                cut_ff, cut_in, extra_ff, extra_in;
   logic                pend_valid_ff, pend_valid_in;
   logic [DW:0]         divr_x_ff, divr_x_in, divr_y_ff, divr_y_in;
   logic [DW-1:0]       divq_x_ff, divq_x_in, divq_y_ff, divq_y_in;

   logic signed [DW-1:0] dx, dy, lx, ly, nx, ny;
   logic [DW+2:0]       rem_sh, trial;
   logic [DW+1:0]       sh_x, sh_y, den;
   logic [PW-1:0]       prod_x, prod_y;
   logic [DW-1:0]       q_x, q_y, rem_ext;
   logic [RW-1:0]       rem_sub, spacing_ext;

   always_comb begin
      spacing_ext = {{(RW - plar_pkg::SPACING_WIDTH){1'b0}}, spacing};
      dx      = {px_ff[CW-1], px_ff} - {last_x_ff[CW-1], last_x_ff};
      dy      = {py_ff[CW-1], py_ff} - {last_y_ff[CW-1], last_y_ff};
      rem_sh  = {sq_rem_ff[DW:0], rad_ff[SW-1 -: 2]};
      trial   = {1'b0, root_ff, 2'b01};
      den     = {2'b00, root_ff};
      sh_x    = {divr_x_ff, divq_x_ff[DW-1]};
      sh_y    = {divr_y_ff, divq_y_ff[DW-1]};
      prod_x  = PW'(ax_ff) * PW'(remaining_ff);
      prod_y  = PW'(ay_ff) * PW'(remaining_ff);
      rem_ext = {{(DW - RW){1'b0}}, remaining_ff};
      rem_sub = remaining_ff - root_ff[RW-1:0];
      // A zero distance only reaches interpolation with zero remaining: no offset.
      q_x     = (root_ff == '0) ? '0 : divq_x_ff;
      q_y     = (root_ff == '0) ? '0 : divq_y_ff;
      lx      = {last_x_ff[CW-1], last_x_ff};
      ly      = {last_y_ff[CW-1], last_y_ff};
      nx      = neg_x_ff ? lx - $signed(q_x) : lx + $signed(q_x);
      ny      = neg_y_ff ? ly - $signed(q_y) : ly + $signed(q_y);
   end

   always_comb begin
      state_in      = state_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      last_x_in     = last_x_ff;
      last_y_in     = last_y_ff;
      pend_x_in     = pend_x_ff;
      pend_y_in     = pend_y_ff;
      last_flag_in  = last_flag_ff;
      remaining_in  = remaining_ff;
      neg_x_in      = neg_x_ff;
      neg_y_in      = neg_y_ff;
      ax_in         = ax_ff;
      ay_in         = ay_ff;
      sqx_in        = sqx_ff;
      sqy_in        = sqy_ff;
      rad_in        = rad_ff;
      sq_rem_in     = sq_rem_ff;
      root_in       = root_ff;
      iter_in       = iter_ff;
      made_in       = made_ff;
      cut_in        = cut_ff;
      extra_in      = extra_ff;
      pend_valid_in = pend_valid_ff;
      divr_x_in     = divr_x_ff;
      divr_y_in     = divr_y_ff;
      divq_x_in     = divq_x_ff;
      divq_y_in     = divq_y_ff;
      cmd_pop       = 1'b0;
      out_push      = 1'b0;
      out_item      = '{out_x: pend_x_ff, out_y: pend_y_ff, run_end: 1'b0, overflow: 1'b0};

      case (state_ff)
         ST_IDLE: begin
            if (cmd_valid) begin
               cmd_pop       = 1'b1;
               px_in         = cmd.pos_x;
               py_in         = cmd.pos_y;
               last_flag_in  = (cmd.kind == plar_pkg::KIND_LAST);
               made_in       = '0;
               cut_in        = 1'b0;
               pend_valid_in = 1'b0;
               if (cmd.kind == plar_pkg::KIND_FIRST) begin
                  last_x_in    = cmd.pos_x;
                  last_y_in    = cmd.pos_y;
                  remaining_in = spacing_ext;
                  extra_in     = 1'b1;
                  state_in     = ST_FINISH;
               end else begin
                  state_in = ST_DELTA;
               end
            end
         end
         ST_DELTA: begin
            neg_x_in = dx[DW-1];
            neg_y_in = dy[DW-1];
            ax_in    = dx[DW-1] ? DW'(-dx) : DW'(dx);
            ay_in    = dy[DW-1] ? DW'(-dy) : DW'(dy);
            state_in = ST_SQUARE;
         end
         ST_SQUARE: begin
            sqx_in   = SW'(ax_ff) * SW'(ax_ff);
            sqy_in   = SW'(ay_ff) * SW'(ay_ff);
            state_in = ST_SUM;
         end
         ST_SUM: begin
            rad_in    = sqx_ff + sqy_ff;
            sq_rem_in = '0;
            root_in   = '0;
            iter_in   = IW'(DW - 1);
            state_in  = ST_SQRT;
         end
         ST_SQRT: begin
            // One result bit per cycle, two radicand bits consumed each time.
            if (rem_sh >= trial) begin
               sq_rem_in = rem_sh - trial;
               root_in   = {root_ff[DW-2:0], 1'b1};
            end else begin
               sq_rem_in = rem_sh;
               root_in   = {root_ff[DW-2:0], 1'b0};
            end
            rad_in  = rad_ff << 2;
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (root_ff < rem_ext) begin
               remaining_in = rem_sub;
               last_x_in    = px_ff;
               last_y_in    = py_ff;
               extra_in     = last_flag_ff && (rem_sub < spacing_ext);
               state_in     = ST_FINISH;
            end else if (made_ff == MW'(MAX_PER_SEGMENT)) begin
               cut_in       = 1'b1;
               last_x_in    = px_ff;
               last_y_in    = py_ff;
               remaining_in = spacing_ext;
               extra_in     = 1'b0;
               state_in     = ST_FINISH;
            end else begin
               state_in = ST_MULT;
            end
         end
         ST_MULT: begin
            // The quotient is bounded by the delta, so the upper product bits
            // start below the divisor.
            divr_x_in = {1'b0, prod_x[PW-1:DW]};
            divr_y_in = {1'b0, prod_y[PW-1:DW]};
            divq_x_in = prod_x[DW-1:0];
            divq_y_in = prod_y[DW-1:0];
            iter_in   = IW'(DW - 1);
            state_in  = ST_DIV;
         end
         ST_DIV: begin
            if (sh_x >= den) begin
               divr_x_in = (DW + 1)'(sh_x - den);
               divq_x_in = {divq_x_ff[DW-2:0], 1'b1};
            end else begin
               divr_x_in = sh_x[DW:0];
               divq_x_in = {divq_x_ff[DW-2:0], 1'b0};
            end
            if (sh_y >= den) begin
               divr_y_in = (DW + 1)'(sh_y - den);
               divq_y_in = {divq_y_ff[DW-2:0], 1'b1};
            end else begin
               divr_y_in = sh_y[DW:0];
               divq_y_in = {divq_y_ff[DW-2:0], 1'b0};
            end
            iter_in = iter_ff - 1'b1;
            if (iter_ff == '0) begin
               state_in = ST_STEP;
            end
         end
         ST_STEP: begin
            // The held point goes out only once a later one proves it is not final.
            if (!(pend_valid_ff && out_full)) begin
               out_push      = pend_valid_ff;
               pend_x_in     = nx[CW-1:0];
               pend_y_in     = ny[CW-1:0];
               pend_valid_in = 1'b1;
               last_x_in     = nx[CW-1:0];
               last_y_in     = ny[CW-1:0];
               remaining_in  = spacing_ext;
               made_in       = made_ff + 1'b1;
               state_in      = ST_DELTA;
            end
         end
         ST_FINISH: begin
            if (pend_valid_ff) begin
               out_item.run_end  = !extra_ff;
               out_item.overflow = cut_ff && !extra_ff;
               if (!out_full) begin
                  out_push      = 1'b1;
                  pend_valid_in = 1'b0;
                  if (!extra_ff) begin
                     state_in = ST_IDLE;
                  end
               end
            end else if (extra_ff) begin
               out_item = '{out_x: px_ff, out_y: py_ff, run_end: 1'b1, overflow: 1'b0};
               if (!out_full) begin
                  out_push = 1'b1;
                  state_in = ST_IDLE;
               end
            end else begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         last_x_ff     <= '0;
         last_y_ff     <= '0;
         remaining_ff  <= {{(RW - plar_pkg::SPACING_WIDTH){1'b0}}, plar_pkg::SPACING_RESET};
         pend_valid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         last_x_ff     <= last_x_in;
         last_y_ff     <= last_y_in;
         remaining_ff  <= remaining_in;
         pend_valid_ff <= pend_valid_in;
      end
      px_ff        <= px_in;
      py_ff        <= py_in;
      pend_x_ff    <= pend_x_in;
      pend_y_ff    <= pend_y_in;
      last_flag_ff <= last_flag_in;
      neg_x_ff     <= neg_x_in;
      neg_y_ff     <= neg_y_in;
      ax_ff        <= ax_in;
      ay_ff        <= ay_in;
      sqx_ff       <= sqx_in;
      sqy_ff       <= sqy_in;
      rad_ff       <= rad_in;
      sq_rem_ff    <= sq_rem_in;
      root_ff      <= root_in;
      iter_ff      <= iter_in;
      made_ff      <= made_in;
      cut_ff       <= cut_in;
      extra_ff     <= extra_in;
      divr_x_ff    <= divr_x_in;
      divr_y_ff    <= divr_y_in;
      divq_x_ff    <= divq_x_in;
      divq_y_ff    <= divq_y_in;
   end

endmodule

/* rtl/polyline_arc_length_resampler.sv */
// Flow: a first vertex passes through the input queue, the engine and the result queue to the result ports.
// A later vertex is measured up to its first distance decision (25-step square root),
// then each interpolated point takes the 25-step divider plus the next measurement, and
// the vertex ends in a finish state; result-side stalls can hold each output.
// Vertices are handled one at a time; the serial square root and divider set the rate.
// Reset clears both queues, the last point to zero and remaining and spacing to 256.
module polyline_arc_length_resampler #(
   parameter int MAX_PER_SEGMENT = 63
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                push,
   output logic                                full,
   input  plar_pkg::req_type                   req_data,
   output logic                                empty,
   input  logic                                pop,
   output plar_pkg::rsp_type                   rsp_data,
   input  logic                                csr_we,
   input  logic [plar_pkg::SPACING_WIDTH-1:0]  csr_wdata
);

   logic [plar_pkg::SPACING_WIDTH-1:0] spacing_ff;
   logic              cmd_valid, cmd_pop, out_full, out_push;
   plar_pkg::cmd_type cmd;
   plar_pkg::rsp_type out_item;

   always_ff @(posedge clock) begin
      if (reset) begin
         spacing_ff <= plar_pkg::SPACING_RESET;
      end else if (csr_we) begin
         spacing_ff <= csr_wdata;
      end
   end

   plar_front u_front (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .cmd_valid (cmd_valid),
      .cmd_pop   (cmd_pop),
      .cmd       (cmd)
   );

   plar_engine #(
      .MAX_PER_SEGMENT (MAX_PER_SEGMENT)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (cmd_valid),
      .cmd       (cmd),
      .cmd_pop   (cmd_pop),
      .spacing   (spacing_ff),
      .out_full  (out_full),
      .out_push  (out_push),
      .out_item  (out_item)
   );

   plar_rsp_fifo u_rsp_fifo (
      .clock    (clock),
      .reset    (reset),
      .in_push  (out_push),
      .in_item  (out_item),
      .in_full  (out_full),
      .empty    (empty),
      .pop      (pop),
      .rsp_data (rsp_data)
   );

endmodule

/* rtl/plar_checker.sv */
// Checker on the top-level ports, bound to the resampler.
module plar_checker (
   input logic              clock,
   input logic              reset,
   input logic              full,
   input logic              empty,
   input logic              pop,
   input plar_pkg::rsp_type rsp_data
);

   a_reset_not_full: assert property (@(posedge clock) reset |=> !full)
      else $error("input queue full right after reset");

   a_reset_empty: assert property (@(posedge clock) reset |=> empty)
      else $error("result queue not empty right after reset");

   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (!empty && !pop) |=> (!empty && $stable(rsp_data)))
      else $error("waiting item changed or vanished");

   a_overflow_final: assert property (@(posedge clock) disable iff (reset)
      (!empty && rsp_data.overflow) |-> rsp_data.run_end)
      else $error("overflow on an item that is not the final one of its vertex");

endmodule

bind polyline_arc_length_resampler plar_checker u_plar_checker (
   .clock    (clock),
   .reset    (reset),
   .full     (full),
   .empty    (empty),
   .pop      (pop),
   .rsp_data (rsp_data)
);

/* dv/polyline_arc_length_resampler_test.sv */
// Self-checking testbench of the polyline arc-length resampler, with a built-in predictor.
`timescale 1ns / 100ps

module polyline_arc_length_resampler_test;

   localparam int  CW            = plar_pkg::COORD_WIDTH;
   localparam int  SPW           = plar_pkg::SPACING_WIDTH;
   localparam int  MAX_POINTS    = 63;
   localparam int  STALL_LIMIT   = 20000;
   localparam int  SETTLE_CYCLES = 2000;
   localparam logic [31:0] CFG_SPACING = 32'd0;   // index of the only register

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     push = 1'b0;
   logic                     full;
   plar_pkg::req_type        req_data = '0;
   logic                     empty;
   logic                     pop = 1'b0;
   plar_pkg::rsp_type        rsp_data;
   logic                     csr_we = 1'b0;
   logic [SPW-1:0]           csr_wdata = '0;

   // Predictor state.
   longint  spacing_now;
   longint  anchor_x, anchor_y;
   longint  left_to_travel;
   plar_pkg::rsp_type points_due[$];

   int  errors = 0;
   int  vertices_sent = 0;
   int  points_checked = 0;
   int  cuts_seen = 0;
   bit  calm = 1'b0;
   int  pop_hold = 0;
   int  quiet_cycles = 0;

   always #4 clock = ~clock;

   polyline_arc_length_resampler i_dut (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .full      (full),
      .req_data  (req_data),
      .empty     (empty),
      .pop       (pop),
      .rsp_data  (rsp_data),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata)
   );

   function automatic longint floor_root(longint sum);
      longint r, c;
      r = 0;
      for (int b = 25; b >= 0; b--) begin
         c = r | (longint'(1) << b);
         if (c * c <= sum) r = c;
      end
      return r;
   endfunction

   function automatic longint move_along(longint from, longint delta, longint num, longint den);
      longint mag, off;
      mag = (delta < 0) ? -delta : delta;
      off = (den == 0) ? 0 : (mag * num) / den;
      return (delta < 0) ? from - off : from + off;
   endfunction

   function automatic void queue_point(longint x, longint y);
      plar_pkg::rsp_type p;
      p.out_x    = x[CW-1:0];
      p.out_y    = y[CW-1:0];
      p.run_end  = 1'b0;
      p.overflow = 1'b0;
      points_due = {points_due, p};
   endfunction

   // Works out the points one vertex causes and appends them to points_due.
   function automatic void predict_points(plar_pkg::req_type v);
      longint px, py, dx, dy, d;
      int     made, start;
      bit     cut;
      px = longint'(v.pos_x);
      py = longint'(v.pos_y);
      start = points_due.size();
      made = 0;
      cut = 1'b0;
      if (v.first_vertex) begin
         anchor_x = px;
         anchor_y = py;
         left_to_travel = spacing_now;
         queue_point(px, py);
      end else begin
         forever begin
            dx = px - anchor_x;
            dy = py - anchor_y;
            d = floor_root(dx * dx + dy * dy);
            if (d < left_to_travel) begin
               left_to_travel -= d;
               anchor_x = px;
               anchor_y = py;
               break;
            end
            if (made >= MAX_POINTS) begin
               cut = 1'b1;
               anchor_x = px;
               anchor_y = py;
               left_to_travel = spacing_now;
               break;
            end
            anchor_x = move_along(anchor_x, dx, left_to_travel, d);
            anchor_y = move_along(anchor_y, dy, left_to_travel, d);
            queue_point(anchor_x, anchor_y);
            made++;
            left_to_travel = spacing_now;
         end
         if (v.last_vertex && left_to_travel < spacing_now) queue_point(px, py);
      end
      if (points_due.size() > start) begin
         points_due[points_due.size()-1].run_end  = 1'b1;
         points_due[points_due.size()-1].overflow = cut;
      end
   endfunction

   // Sends one vertex; push stays high unless a random pause is taken, so the next call can follow without a gap.
   task automatic send_vertex(input logic signed [CW-1:0] x,
                              input logic signed [CW-1:0] y,
                              input bit first, input bit last);
      plar_pkg::req_type v;
      v.pos_x = x;
      v.pos_y = y;
      v.first_vertex = first;
      v.last_vertex = last;
      req_data <= v;
      push <= 1'b1;
      @(posedge clock);
      while (full) @(posedge clock);
      predict_points(v);
      vertices_sent++;
      if (!calm && $urandom_range(0, 3) == 0) begin
         push <= 1'b0;
         repeat ($urandom_range(1, 5)) @(posedge clock);
      end
   endtask

   // Waits until every point has arrived and the block has had time to finish.
   task automatic settle();
      push <= 1'b0;
      @(posedge clock);
      while (points_due.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_spacing(input logic [SPW-1:0] value);
      settle();
      csr_we <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      if (CFG_SPACING == 0) spacing_now = longint'(value);
   endtask

   // A random walk of len vertices with steps up to max_step per axis.
   task automatic send_polyline(input int len, input int max_step);
      int margin;
      int x, y;
      margin = 8388607 - len * max_step - 1;
      x = $urandom_range(0, 2 * margin) - margin;
      y = $urandom_range(0, 2 * margin) - margin;
      for (int i = 0; i < len; i++) begin
         if (i > 0) begin
            x += $urandom_range(0, 2 * max_step) - max_step;
            y += $urandom_range(0, 2 * max_step) - max_step;
         end
         send_vertex(CW'(x), CW'(y), i == 0, i == len - 1);
      end
   endtask

   task automatic test_orphan_vertex();
      // No first vertex since reset: the walk starts at the origin.
      send_vertex(24'sd700, -24'sd300, 1'b0, 1'b0);
      send_vertex(24'sd100, 24'sd50, 1'b0, 1'b1);
      send_vertex(24'sd10, 24'sd20, 1'b0, 1'b0);
   endtask

   task automatic test_single_vertex();
      send_vertex(24'sd1234, -24'sd77, 1'b1, 1'b1);
      send_vertex(24'sd0, 24'sd0, 1'b1, 1'b0);
      send_vertex(24'sd0, 24'sd0, 1'b0, 1'b1);
   endtask

   task automatic test_extremes();
      send_vertex(-24'sd8388608, -24'sd8388608, 1'b1, 1'b0);
      send_vertex(24'sd8388607, 24'sd8388607, 1'b0, 1'b1);
      send_vertex(24'sd8388607, -24'sd8388608, 1'b1, 1'b0);
      send_vertex(24'sd8388607, -24'sd8388000, 1'b0, 1'b0);
      send_vertex(-24'sd8388608, 24'sd8388607, 1'b0, 1'b1);
   endtask

   task automatic test_spacing_limits();
      write_spacing(23'd1);
      send_vertex(24'sd0, 24'sd0, 1'b1, 1'b0);
      send_vertex(24'sd40, -24'sd30, 1'b0, 1'b0);
      send_vertex(24'sd200, 24'sd100, 1'b0, 1'b1);
      write_spacing(23'h7FFFFF);
      send_vertex(24'sd5, 24'sd5, 1'b1, 1'b0);
      send_vertex(24'sd4000, -24'sd9000, 1'b0, 1'b0);
      send_vertex(24'sd8388607, 24'sd8388607, 1'b0, 1'b1);
      // Spacing changes in the middle of a polyline; remaining keeps its value.
      send_vertex(24'sd0, 24'sd0, 1'b1, 1'b0);
      send_vertex(24'sd300, 24'sd0, 1'b0, 1'b0);
      write_spacing(23'd128);
      send_vertex(24'sd900, 24'sd0, 1'b0, 1'b1);
   endtask

   task automatic test_zero_spacing();
      // Every measurement emits, so a repeated vertex hits the segment limit.
      write_spacing(23'd0);
      send_vertex(24'sd50, 24'sd60, 1'b1, 1'b0);
      send_vertex(24'sd50, 24'sd60, 1'b0, 1'b0);
      send_vertex(24'sd51, 24'sd60, 1'b0, 1'b1);
   endtask

   task automatic test_random_polylines();
      int sent;
      sent = 0;
      while (sent < 125) begin
         if ($urandom_range(0, 4) == 0) begin
            write_spacing(SPW'($urandom_range(0, 7) == 0 ? $urandom_range(1, 23'h7FFFFF)
                                                         : $urandom_range(64, 2048)));
         end
         if ($urandom_range(0, 5) == 0) begin
            send_vertex(CW'($urandom), CW'($urandom),
                        1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)));
            sent++;
         end else begin
            int len;
            len = $urandom_range(2, 8);
            send_polyline(len, $urandom_range(0, 3) == 0 ? 16 : 4096);
            sent += len;
         end
         if (sent > 100) calm = 1'b1;
      end
   endtask

   // Result side: random pop stalls, checking and the watchdog.
   always @(posedge clock) begin
      plar_pkg::rsp_type want;
      if (!reset) begin
         if (pop && !empty) begin
            if (points_due.size() == 0) begin
               $error("point with no vertex waiting for it: x=%0d y=%0d",
                      rsp_data.out_x, rsp_data.out_y);
               errors++;
            end else begin
               want = points_due.pop_front();
               if (rsp_data.out_x !== want.out_x) begin
                  $error("out_x: expected %0d, got %0d", want.out_x, rsp_data.out_x);
                  errors++;
               end
               if (rsp_data.out_y !== want.out_y) begin
                  $error("out_y: expected %0d, got %0d", want.out_y, rsp_data.out_y);
                  errors++;
               end
               if (rsp_data.run_end !== want.run_end) begin
                  $error("run_end: expected %0b, got %0b", want.run_end, rsp_data.run_end);
                  errors++;
               end
               if (rsp_data.overflow !== want.overflow) begin
                  $error("overflow: expected %0b, got %0b", want.overflow, rsp_data.overflow);
                  errors++;
               end
               if (rsp_data.overflow === 1'b1) cuts_seen++;
            end
            points_checked++;
         end
         if ((pop && !empty) || (push && !full)) quiet_cycles = 0;
         else quiet_cycles++;
         if (quiet_cycles >= STALL_LIMIT) begin
            $display("watchdog: nothing moved for %0d cycles", STALL_LIMIT);
            $display("RESULT: ERROR");
            $finish;
         end
         if (pop_hold > 0) begin
            pop <= 1'b0;
            pop_hold--;
         end else if (!calm && $urandom_range(0, 3) == 0) begin
            pop <= 1'b0;
            pop_hold = $urandom_range(0, 4);
         end else begin
            pop <= 1'b1;
         end
      end
   end

   initial begin
      spacing_now = longint'(plar_pkg::SPACING_RESET);
      anchor_x = 0;
      anchor_y = 0;
      left_to_travel = spacing_now;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_orphan_vertex();
      test_single_vertex();
      test_extremes();
      test_spacing_limits();
      test_zero_spacing();
      write_spacing(plar_pkg::SPACING_RESET);
      test_random_polylines();
      settle();
      $display("Sent %0d vertices over several spacings, including zero and the largest;",
               vertices_sent);
      $display("checked %0d points, %0d of them ending a segment cut short.",
               points_checked, cuts_seen);
      if (errors == 0) begin
         $display("RESULT: OK");
      end else begin
         $display("RESULT: ERROR");
      end
      $finish;
   end

endmodule
